### rtl/slir_pkg.sv
// ----------------------------------------------------------------------------
// slir_pkg: shared types and codes of the sorted list
// operation and status codes, control and neighbor flag bundles
// ----------------------------------------------------------------------------
package slir_pkg;

    localparam int COUNT_OUT_W = 7;
    localparam int M_TDATA_W   = 8;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2
    } status_t;

    // broadcast to every cell of the row
    typedef struct packed {
        logic insert_en;
        logic remove_en;
        logic found;
    } slir_ctrl_t;

    // handed from a cell to its right neighbor
    typedef struct packed {
        logic after;   // empty or entry > key
        logic ge;      // valid and entry >= key
    } slir_flags_t;

endpackage

### rtl/slir_cell.sv
// ----------------------------------------------------------------------------
// slir_cell: one entry of the sorted row
// compares its entry with the key and shifts toward either neighbor
// ----------------------------------------------------------------------------
module slir_cell
    import slir_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic [VALUE_WIDTH-1:0] key,
    input  slir_ctrl_t             ctrl,
    input  logic                   valid_in,
    input  slir_flags_t            left_flags,
    input  logic [VALUE_WIDTH-1:0] left_value,
    input  logic [VALUE_WIDTH-1:0] right_value,
    output slir_flags_t            flags,
    output logic                   first_eq,
    output logic [VALUE_WIDTH-1:0] value_out
);

    logic [VALUE_WIDTH-1:0] entry_reg;
    logic [VALUE_WIDTH-1:0] entry_next;
    logic                   gt;

    assign gt        = valid_in && ($signed(entry_reg) > $signed(key));
    assign flags.ge  = valid_in && ($signed(entry_reg) >= $signed(key));
    assign flags.after = !valid_in || gt;
    // first equal entry: left neighbor is still below the key
    assign first_eq  = valid_in && (entry_reg == key) && !left_flags.ge;
    assign value_out = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.insert_en) begin
            if (left_flags.after) begin
                entry_next = left_value;
            end else if (flags.after) begin
                entry_next = key;
            end
        end else if (ctrl.remove_en && ctrl.found && flags.ge) begin
            entry_next = right_value;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

### rtl/sorted_list_insert_remove.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_remove: ordered list of signed values
// insert in order and remove of the first equal entry, one status per request
// ----------------------------------------------------------------------------
// The list is a row of CAPACITY cells, each holding one entry. When a request
// is taken, every cell compares its entry with the key at once, an
// insert opens a gap by moving the greater entries one cell to the right, and
// a remove closes the gap by moving the entries at and after the first equal
// entry one cell to the left. Equal values keep arrival order. One request is
// accepted per clock; that figure is set by the per-cell compare and the
// found reduction across the row, both settled in the accept cycle. The
// result (status and new count) sits in an output register; the next request
// is taken in the same cycle that the waiting result is accepted, and a
// stalled result holds the request channel. An insert into a full list is
// answered with the full status, a remove of an absent value with not found;
// the list is unchanged in both cases. No clearing pass is needed after reset.
module sorted_list_insert_remove
    import slir_pkg::*;
#(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // request channel
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]       s_tdata,   // value
    input  logic [0:0]                             s_tuser,   // operation
    // result channel
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [M_TDATA_W-1:0]                   m_tdata,   // entry_count
    output logic [1:0]                             m_tuser    // status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // count of held entries
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // result register
    logic                   m_tvalid_reg;
    logic                   m_tvalid_next;
    status_t                m_status_reg;
    status_t                m_status_next;
    logic [COUNT_OUT_W-1:0] m_count_reg;

    logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

    logic                   accept;
    logic                   full;
    op_t                    op;
    logic [VALUE_WIDTH-1:0] key;
    slir_ctrl_t             ctrl;

    // row wiring
    slir_flags_t            flags    [CAPACITY];
    logic [VALUE_WIDTH-1:0] values   [CAPACITY];
    logic [CAPACITY-1:0]    first_eq;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign op       = op_t'(s_tuser[0]);
    assign key      = s_tdata[VALUE_WIDTH-1:0];
    assign full     = (count_reg == CNT_W'(CAPACITY));

    assign ctrl.insert_en = accept && (op == OP_INSERT) && !full;
    assign ctrl.remove_en = accept && (op == OP_REMOVE);
    // at most one cell sees its first equal entry
    assign ctrl.found     = |first_eq;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            slir_flags_t            lf;
            logic [VALUE_WIDTH-1:0] lv;
            logic [VALUE_WIDTH-1:0] rv;

            if (gi == 0) begin : g_head
                assign lf = '0;
                assign lv = '0;
            end else begin : g_body
                assign lf = flags[gi-1];
                assign lv = values[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                assign rv = values[gi];
            end else begin : g_mid
                assign rv = values[gi+1];
            end

            slir_cell #(
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .aclk        (aclk),
                .key         (key),
                .ctrl        (ctrl),
                .valid_in    (CNT_W'(gi) < count_reg),
                .left_flags  (lf),
                .left_value  (lv),
                .right_value (rv),
                .flags       (flags[gi]),
                .first_eq    (first_eq[gi]),
                .value_out   (values[gi])
            );
        end
    endgenerate

    // next count, status and result valid
    always_comb begin
        count_next    = count_reg;
        m_status_next = m_status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (accept) begin
            m_tvalid_next = 1'b1;
            unique case (op)
                OP_INSERT: begin
                    if (full) begin
                        m_status_next = STATUS_FULL;
                    end else begin
                        m_status_next = STATUS_DONE;
                        count_next    = count_reg + CNT_W'(1);
                    end
                end
                OP_REMOVE: begin
                    if (ctrl.found) begin
                        m_status_next = STATUS_DONE;
                        count_next    = count_reg - CNT_W'(1);
                    end else begin
                        m_status_next = STATUS_NOT_FOUND;
                    end
                end
                default: begin
                    m_status_next = m_status_reg;
                end
            endcase
        end
    end

    // low bits of the new count go out
    assign count_ext = {{COUNT_OUT_W{1'b0}}, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // result payload, loaded with each request
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_status_reg <= m_status_next;
            m_count_reg  <= count_ext[COUNT_OUT_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{(M_TDATA_W-COUNT_OUT_W){1'b0}}, m_count_reg};

endmodule

### rtl/slir_checker.sv
// ----------------------------------------------------------------------------
// slir_port_checker: port-level checks of the sorted list
// result codes and counts seen on the result channel
// ----------------------------------------------------------------------------
module slir_port_checker
    import slir_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [1:0]           m_tuser
);

    localparam logic [M_TDATA_W-1:0] CAP_LOW = M_TDATA_W'(CAPACITY % 128);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // every request leaves a result behind
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("request without result");

    // full status only with the list at capacity
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STATUS_FULL) |-> m_tdata == CAP_LOW)
        else $error("full status with wrong count");

    // count never beyond capacity (checked for CAPACITY up to 127), no unused status code
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser != 2'd3) && ((CAPACITY > 127) || (m_tdata <= CAP_LOW)))
        else $error("result out of range");

endmodule

bind sorted_list_insert_remove slir_port_checker #(
    .CAPACITY (CAPACITY)
) u_slir_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
